// ===== sv/bts_pkg.sv =====
// bts_pkg: shared types and constants for the bilinear texture sampler
// no dependencies

package bts_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam int SIZE_BITS  = 9;
   localparam int GAIN_BITS  = 16;
   localparam int CHAN_BITS  = 16;
   localparam int TEXEL_BITS = 3 * CHAN_BITS;
   localparam int COORD_BITS = 32;
   localparam int POS_BITS   = 26;   // signed Q10.16 pixel position after border handling
   localparam int IDX_BITS   = 11;   // signed texel index with one wrap step of room
   localparam int NUM_PORTS  = 4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPOSURE_GAIN = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BORDER_MODE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_MODE   = 3'd4;

   localparam logic OP_WRITE       = 1'b0;
   localparam logic OP_SAMPLE      = 1'b1;
   localparam logic BORDER_CLAMP   = 1'b0;
   localparam logic BORDER_REPEAT  = 1'b1;
   localparam logic FILTER_NEAREST = 1'b0;
   localparam logic FILTER_BILINEAR = 1'b1;

   localparam logic [SIZE_BITS-1:0] RESET_SIZE = 9'd256;
   localparam logic [GAIN_BITS-1:0] RESET_GAIN = 16'd256;

   localparam logic [16:0] ONE_Q16 = 17'h10000;
   localparam logic signed [POS_BITS-1:0] HALF_Q16 = 26'sd32768;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } texel_type;

endpackage

// ===== sv/bilinear_texture_sampler.sv =====
// One transaction per cycle sustained while each result is taken.
// Texel writes land in the texel memory from the stage 3 registers, in order with samples.
// Four copies of the texel memory give the four neighbour reads in one cycle.
// A result not taken holds the whole pipeline; req_ready drops only then.
// Sync reset clears valid bits, sets CSR defaults; texel memory is undefined until written.
// Depends on bts_pkg.

module bilinear_texture_sampler #(
   parameter int MAX_WIDTH  = bts_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bts_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [bts_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bts_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [7:0]                           req_texel_col,
   input  logic [7:0]                           req_texel_row,
   input  logic [15:0]                          req_texel_red,
   input  logic [15:0]                          req_texel_green,
   input  logic [15:0]                          req_texel_blue,
   input  logic signed [31:0]                   req_coord_u,
   input  logic signed [31:0]                   req_coord_v,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [15:0]                          rsp_out_red,
   output logic [15:0]                          rsp_out_green,
   output logic [15:0]                          rsp_out_blue
);
   import bts_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int AW    = CW + RW;
   localparam int DEPTH = 1 << AW;

   // configuration
   logic [SIZE_BITS-1:0] width_ff, height_ff;
   logic [GAIN_BITS-1:0] gain_ff;
   logic                 border_ff, filter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_SIZE;
         height_ff <= RESET_SIZE;
         gain_ff   <= RESET_GAIN;
         border_ff <= BORDER_REPEAT;
         filter_ff <= FILTER_BILINEAR;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_data[SIZE_BITS-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_data[SIZE_BITS-1:0];
            CSR_EXPOSURE_GAIN: gain_ff   <= csr_data;
            CSR_BORDER_MODE:   border_ff <= csr_data[0];
            CSR_FILTER_MODE:   filter_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [SIZE_BITS-1:0] w_eff, h_eff;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = SIZE_BITS'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = SIZE_BITS'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = SIZE_BITS'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = SIZE_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // whole pipeline moves unless the output register holds an untaken result
   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // stage 1: input register
   logic                    v1_ff, op1_ff;
   logic [7:0]              col1_ff, row1_ff;
   texel_type               tex1_ff;
   logic signed [31:0]      u1_ff, v1c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
      end
      if (advance) begin
         op1_ff  <= req_op;
         col1_ff <= req_texel_col;
         row1_ff <= req_texel_row;
         tex1_ff <= '{red: req_texel_red, green: req_texel_green, blue: req_texel_blue};
         u1_ff   <= req_coord_u;
         v1c_ff  <= req_coord_v;
      end
   end

   // stage 2: pixel positions, both the plain and the fractional (repeat) form
   logic signed [SIZE_BITS:0]   w_s, h_s;
   logic signed [41:0]          pxm, pym;
   logic [24:0]                 rxm, rym;
   logic signed [41:0]          px2_in, py2_in;
   logic signed [POS_BITS-1:0]  rx2_in, ry2_in;
   logic signed [41:0]          px2_ff, py2_ff;
   logic signed [POS_BITS-1:0]  rx2_ff, ry2_ff;
   logic                        v2_ff, op2_ff;
   logic [7:0]                  col2_ff, row2_ff;
   texel_type                   tex2_ff;

   always_comb begin
      w_s    = $signed({1'b0, w_eff});
      h_s    = $signed({1'b0, h_eff});
      pxm    = w_s * u1_ff;
      pym    = h_s * v1c_ff;
      rxm    = w_eff * u1_ff[15:0];
      rym    = h_eff * v1c_ff[15:0];
      px2_in = pxm - 42'sd32768;
      py2_in = pym - 42'sd32768;
      rx2_in = $signed({1'b0, rxm}) - HALF_Q16;
      ry2_in = $signed({1'b0, rym}) - HALF_Q16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         px2_ff  <= px2_in;
         py2_ff  <= py2_in;
         rx2_ff  <= rx2_in;
         ry2_ff  <= ry2_in;
         op2_ff  <= op1_ff;
         col2_ff <= col1_ff;
         row2_ff <= row1_ff;
         tex2_ff <= tex1_ff;
      end
   end

   // stage 3: border handling
   logic [24:0]                 hiw, hih;
   logic                        outside;
   logic signed [POS_BITS-1:0]  px3_in, py3_in;
   logic signed [POS_BITS-1:0]  px3_ff, py3_ff;
   logic                        v3_ff, op3_ff;
   logic [7:0]                  col3_ff, row3_ff;
   texel_type                   tex3_ff;

   always_comb begin
      hiw = {w_eff - SIZE_BITS'(1), 16'b0};
      hih = {h_eff - SIZE_BITS'(1), 16'b0};
      outside = px2_ff < 0 || px2_ff > $signed({17'b0, hiw})
             || py2_ff < 0 || py2_ff > $signed({17'b0, hih});
      px3_in = px2_ff[POS_BITS-1:0];
      py3_in = py2_ff[POS_BITS-1:0];
      if (outside) begin
         if (border_ff == BORDER_CLAMP) begin
            if (px2_ff < 0) begin
               px3_in = '0;
            end else if (px2_ff > $signed({17'b0, hiw})) begin
               px3_in = $signed({1'b0, hiw});
            end
            if (py2_ff < 0) begin
               py3_in = '0;
            end else if (py2_ff > $signed({17'b0, hih})) begin
               py3_in = $signed({1'b0, hih});
            end
         end else begin
            px3_in = rx2_ff;
            py3_in = ry2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
      if (advance) begin
         px3_ff  <= px3_in;
         py3_ff  <= py3_in;
         op3_ff  <= op2_ff;
         col3_ff <= col2_ff;
         row3_ff <= row2_ff;
         tex3_ff <= tex2_ff;
      end
   end

   // stage 4: texel addresses, memory write and four reads
   logic signed [POS_BITS-1:0]  sx, sy;
   logic [POS_BITS-1:0]         ty;
   logic [9:0]                  ncol, nrow;
   logic signed [IDX_BITS-1:0]  w_i, h_i, fx0, fy0, cx0, cy0, rf, rc;
   logic [15:0]                 fx, fy;
   logic [AW-1:0]               rd_addr [NUM_PORTS];
   logic [AW-1:0]               wr_addr;
   logic                        wr_en;

   always_comb begin
      w_i = $signed({2'b0, w_eff});
      h_i = $signed({2'b0, h_eff});
      // nearest
      sx   = px3_ff + HALF_Q16;
      sy   = py3_ff + HALF_Q16;
      ty   = POS_BITS'({h_eff, 16'b0}) - unsigned'(sy);
      ncol = sx[POS_BITS-1:16];
      nrow = ty[POS_BITS-1:16];
      if (nrow > {1'b0, h_eff - SIZE_BITS'(1)}) begin
         nrow = {1'b0, h_eff - SIZE_BITS'(1)};
      end
      // bilinear, neighbours wrap around the image
      fx  = px3_ff[15:0];
      fy  = py3_ff[15:0];
      fx0 = IDX_BITS'(px3_ff >>> 16);
      fy0 = IDX_BITS'(py3_ff >>> 16);
      cx0 = fx0 + IDX_BITS'(fx != '0);
      cy0 = fy0 + IDX_BITS'(fy != '0);
      if (fx0 < 0) fx0 = fx0 + w_i;
      if (fy0 < 0) fy0 = fy0 + h_i;
      if (cx0 > w_i - IDX_BITS'(1)) cx0 = cx0 - w_i;
      if (cy0 > h_i - IDX_BITS'(1)) cy0 = cy0 - h_i;
      // rows are stored flipped
      rf = h_i - IDX_BITS'(1) - fy0;
      rc = h_i - IDX_BITS'(1) - cy0;
      if (filter_ff == FILTER_NEAREST) begin
         rd_addr[0] = {RW'(nrow), CW'(ncol)};
      end else begin
         rd_addr[0] = {RW'(unsigned'(rf)), CW'(unsigned'(fx0))};
      end
      rd_addr[1] = {RW'(unsigned'(rf)), CW'(unsigned'(cx0))};
      rd_addr[2] = {RW'(unsigned'(rc)), CW'(unsigned'(fx0))};
      rd_addr[3] = {RW'(unsigned'(rc)), CW'(unsigned'(cx0))};
      wr_addr = {RW'(row3_ff), CW'(col3_ff)};
      wr_en   = advance && v3_ff && op3_ff == OP_WRITE
             && 32'(col3_ff) < MAX_WIDTH && 32'(row3_ff) < MAX_HEIGHT;
   end

   texel_type rd_ff [NUM_PORTS];

   for (genvar b = 0; b < NUM_PORTS; b++) begin : g_bank
      texel_type mem [DEPTH];
      always_ff @(posedge clock) begin
         if (wr_en) begin
            mem[wr_addr] <= tex3_ff;
         end
         if (advance) begin
            rd_ff[b] <= mem[rd_addr[b]];
         end
      end
   end

   logic        v4_ff, near4_ff;
   logic [15:0] fx4_ff, fy4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff && op3_ff == OP_SAMPLE;
      end
      if (advance) begin
         near4_ff <= filter_ff == FILTER_NEAREST;
         fx4_ff   <= fx;
         fy4_ff   <= fy;
      end
   end

   // stage 5: horizontal blend, top and bottom rows
   logic [16:0] wfx;
   logic [31:0] top5_in [3];
   logic [31:0] bot5_in [3];
   logic [31:0] top5_ff [3];
   logic [31:0] bot5_ff [3];
   logic        v5_ff, near5_ff;
   logic [15:0] fy5_ff;
   texel_type   tex5_ff;

   always_comb begin
      wfx = ONE_Q16 - {1'b0, fx4_ff};
      for (int c = 0; c < 3; c++) begin
         top5_in[c] = {16'b0, rd_ff[0][16*c +: 16]} * {15'b0, wfx}
                    + {16'b0, rd_ff[1][16*c +: 16]} * {16'b0, fx4_ff};
         bot5_in[c] = {16'b0, rd_ff[2][16*c +: 16]} * {15'b0, wfx}
                    + {16'b0, rd_ff[3][16*c +: 16]} * {16'b0, fx4_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
      if (advance) begin
         top5_ff  <= top5_in;
         bot5_ff  <= bot5_in;
         near5_ff <= near4_ff;
         fy5_ff   <= fy4_ff;
         tex5_ff  <= rd_ff[0];
      end
   end

   // stage 6: vertical blend
   logic [16:0] wfy;
   logic [47:0] sum6_in [3];
   logic [47:0] sum6_ff [3];
   logic        v6_ff, near6_ff;
   texel_type   tex6_ff;

   always_comb begin
      wfy = ONE_Q16 - {1'b0, fy5_ff};
      for (int c = 0; c < 3; c++) begin
         sum6_in[c] = {16'b0, top5_ff[c]} * {31'b0, wfy}
                    + {16'b0, bot5_ff[c]} * {32'b0, fy5_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= v5_ff;
      end
      if (advance) begin
         sum6_ff  <= sum6_in;
         near6_ff <= near5_ff;
         tex6_ff  <= tex5_ff;
      end
   end

   // stage 7: exposure, split into two 24x16 partial products
   logic [39:0] lo7_in [3];
   logic [39:0] hi7_in [3];
   logic [39:0] lo7_ff [3];
   logic [39:0] hi7_ff [3];
   logic        v7_ff, near7_ff;
   texel_type   tex7_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         lo7_in[c] = {16'b0, sum6_ff[c][23:0]} * {24'b0, gain_ff};
         hi7_in[c] = {16'b0, sum6_ff[c][47:24]} * {24'b0, gain_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (advance) begin
         v7_ff <= v6_ff;
      end
      if (advance) begin
         lo7_ff   <= lo7_in;
         hi7_ff   <= hi7_in;
         near7_ff <= near6_ff;
         tex7_ff  <= tex6_ff;
      end
   end

   // stage 8: remove the Q8.8 gain scale rounding half up, saturate, output register
   logic [64:0] tot  [3];
   logic [15:0] chan [3];
   texel_type   out8_in, out8_ff;
   logic        v8_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         tot[c] = {1'b0, hi7_ff[c], 24'b0} + {25'b0, lo7_ff[c]} + (65'd1 << 39);
         chan[c] = (tot[c][64:56] != '0) ? 16'hFFFF : tot[c][55:40];
      end
      if (near7_ff) begin
         out8_in = tex7_ff;
      end else begin
         out8_in = '{red: chan[2], green: chan[1], blue: chan[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (advance) begin
         v8_ff <= v7_ff;
      end
      if (advance) begin
         out8_ff <= out8_in;
      end
   end

   assign rsp_valid     = v8_ff;
   assign rsp_out_red   = out8_ff.red;
   assign rsp_out_green = out8_ff.green;
   assign rsp_out_blue  = out8_ff.blue;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for bilinear_texture_sampler
// depends on bts_pkg and the bilinear_texture_sampler rtl

import bts_pkg::*;

class texel_scoreboard;
   texel_type texel_mem [65536];
   bit        written [65536];
   int        image_width;
   int        image_height;
   longint    exposure_gain;
   bit        border_mode;
   bit        filter_mode;
   texel_type expected_texels [$];
   int        errors;

   function new();
      image_width = RESET_SIZE;
      image_height = RESET_SIZE;
      exposure_gain = RESET_GAIN;
      border_mode = BORDER_REPEAT;
      filter_mode = FILTER_BILINEAR;
      errors = 0;
   endfunction

   function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_IMAGE_WIDTH: begin
            image_width = data[SIZE_BITS-1:0];
         end
         CSR_IMAGE_HEIGHT: begin
            image_height = data[SIZE_BITS-1:0];
         end
         CSR_EXPOSURE_GAIN: begin
            exposure_gain = data;
         end
         CSR_BORDER_MODE: begin
            border_mode = data[0];
         end
         CSR_FILTER_MODE: begin
            filter_mode = data[0];
         end
         default: ;
      endcase
   endfunction

   function longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function longint eff_size(int s);
      if (s == 0) return 1;
      if (s > 256) return 256;
      return s;
   endfunction

   // texel addresses that a sample reads under the current settings
   function void locate(logic signed [31:0] cu, logic signed [31:0] cv,
                        output int c0, output int c1, output int r0, output int r1,
                        output longint fx, output longint fy);
      longint w, h, u, v, px, py, hiw, hih, fx0, fy0, cx0, cy0;
      w = eff_size(image_width);
      h = eff_size(image_height);
      u = cu;
      v = cv;
      hiw = (w - 1) * 65536;
      hih = (h - 1) * 65536;
      px = w * u - 32768;
      py = h * v - 32768;
      if (px < 0 || px > hiw || py < 0 || py > hih) begin
         if (border_mode == BORDER_CLAMP) begin
            px = clip(px, 0, hiw);
            py = clip(py, 0, hih);
         end else begin
            px = w * (u & 64'hFFFF) - 32768;
            py = h * (v & 64'hFFFF) - 32768;
         end
      end
      if (filter_mode == FILTER_NEAREST) begin
         c0 = int'(clip((px + 32768) >>> 16, 0, w - 1));
         r0 = int'(clip((h * 65536 - (py + 32768)) >>> 16, 0, h - 1));
         c1 = c0;
         r1 = r0;
         fx = 0;
         fy = 0;
      end else begin
         fx0 = px >>> 16;
         fy0 = py >>> 16;
         fx = px & 64'hFFFF;
         fy = py & 64'hFFFF;
         cx0 = fx0 + (fx != 0);
         cy0 = fy0 + (fy != 0);
         if (fx0 < 0) fx0 += w;
         if (fy0 < 0) fy0 += h;
         if (cx0 > w - 1) cx0 -= w;
         if (cy0 > h - 1) cy0 -= h;
         c0 = int'(clip(fx0, 0, w - 1));
         c1 = int'(clip(cx0, 0, w - 1));
         r0 = int'(clip((h - 1) - fy0, 0, h - 1));
         r1 = int'(clip((h - 1) - cy0, 0, h - 1));
      end
   endfunction

   function longint unsigned chan(texel_type t, int ch);
      return ch == 0 ? t.red : (ch == 1 ? t.green : t.blue);
   endfunction

   function void note_request(logic op, logic [7:0] col, logic [7:0] row, texel_type data,
                              logic signed [31:0] cu, logic signed [31:0] cv);
      int c0, c1, r0, r1;
      longint fx, fy;
      longint unsigned top, bot, sum, r;
      logic [15:0] res [3];
      if (op == OP_WRITE) begin
         texel_mem[{row, col}] = data;
         written[{row, col}] = 1;
         return;
      end
      locate(cu, cv, c0, c1, r0, r1, fx, fy);
      for (int ch = 0; ch < 3; ch++) begin
         if (filter_mode == FILTER_NEAREST) begin
            res[ch] = 16'(chan(texel_mem[r0 * 256 + c0], ch));
         end else begin
            top = chan(texel_mem[r0 * 256 + c0], ch) * (65536 - fx)
                + chan(texel_mem[r0 * 256 + c1], ch) * fx;
            bot = chan(texel_mem[r1 * 256 + c0], ch) * (65536 - fx)
                + chan(texel_mem[r1 * 256 + c1], ch) * fx;
            sum = top * (65536 - fy) + bot * fy;
            r = (sum * exposure_gain + (64'd1 << 39)) >> 40;
            res[ch] = r > 65535 ? 16'hFFFF : r[15:0];
         end
      end
      expected_texels.push_back('{res[0], res[1], res[2]});
   endfunction

   function void check_response(texel_type got);
      texel_type exp_t;
      if (expected_texels.size() == 0) begin
         $error("unexpected response transaction");
         errors++;
         return;
      end
      exp_t = expected_texels.pop_front();
      if (got.red !== exp_t.red) begin
         $error("out_red expected %h actual %h", exp_t.red, got.red);
         errors++;
      end
      if (got.green !== exp_t.green) begin
         $error("out_green expected %h actual %h", exp_t.green, got.green);
         errors++;
      end
      if (got.blue !== exp_t.blue) begin
         $error("out_blue expected %h actual %h", exp_t.blue, got.blue);
         errors++;
      end
   endfunction
endclass

module tb_top;
   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic req_op = 0;
   logic [7:0] req_texel_col = 0, req_texel_row = 0;
   logic [15:0] req_texel_red = 0, req_texel_green = 0, req_texel_blue = 0;
   logic signed [31:0] req_coord_u = 0, req_coord_v = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [15:0] rsp_out_red, rsp_out_green, rsp_out_blue;

   texel_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;

   bilinear_texture_sampler u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver with random stalls and an optional long hold-off
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response('{rsp_out_red, rsp_out_green, rsp_out_blue});
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_item(logic op, logic [7:0] col, logic [7:0] row, texel_type data,
                            logic signed [31:0] cu, logic signed [31:0] cv);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_op <= op;
      req_texel_col <= col;
      req_texel_row <= row;
      req_texel_red <= data.red;
      req_texel_green <= data.green;
      req_texel_blue <= data.blue;
      req_coord_u <= cu;
      req_coord_v <= cv;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, col, row, data, cu, cv);
   endtask

   task automatic write_texel(int col, int row);
      send_item(OP_WRITE, 8'(col), 8'(row), texel_type'({$urandom, $urandom}),
                $urandom, $urandom);
   endtask

   // fills any texel the sample would read that was never written
   task automatic sample_at(logic signed [31:0] cu, logic signed [31:0] cv);
      int c[2], r[2];
      longint fx, fy;
      sb.locate(cu, cv, c[0], c[1], r[0], r[1], fx, fy);
      foreach (c[i])
         foreach (r[j])
            if (!sb.written[r[j] * 256 + c[i]])
               write_texel(c[i], r[j]);
      send_item(OP_SAMPLE, 8'($urandom), 8'($urandom), texel_type'({$urandom, $urandom}),
                cu, cv);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.expected_texels.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(negedge clock);
      csr_write_enable <= 0;
      sb.set_reg(idx, data);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(65535);
         2: return 32'($urandom_range(3 * 65536)) - 32'sd65536;
         3: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
         4: return {16'($urandom_range(3)), 16'($urandom)};
         default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
      endcase
   endfunction

   task automatic random_items(int count);
      repeat (count) begin
         if ($urandom_range(99) < 25)
            write_texel($urandom_range(255), $urandom_range(255));
         else
            sample_at(rand_coord(), rand_coord());
      end
   endtask

   int widths [7]  = '{256, 1, 3, 0, 511, 17, 256};
   int heights [7] = '{256, 1, 5, 300, 2, 9, 256};
   int gains [7]   = '{65535, 0, 128, 256, 700, 65535, 1};
   bit borders [7] = '{BORDER_CLAMP, BORDER_REPEAT, BORDER_CLAMP, BORDER_REPEAT,
                       BORDER_CLAMP, BORDER_REPEAT, BORDER_CLAMP};
   bit filters [7] = '{FILTER_BILINEAR, FILTER_NEAREST, FILTER_BILINEAR, FILTER_BILINEAR,
                       FILTER_NEAREST, FILTER_BILINEAR, FILTER_NEAREST};

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_idle_pct = 8;
      recv_idle_pct = 81;

      // directed: channel extremes, corners, coordinate extremes, texel centers
      send_item(OP_WRITE, 8'd0, 8'd0, '{16'hFFFF, 16'h0000, 16'hFFFF}, 0, 0);
      send_item(OP_WRITE, 8'd255, 8'd255, '{16'h0000, 16'hFFFF, 16'h0000}, 0, 0);
      send_item(OP_WRITE, 8'd255, 8'd0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, 0);
      send_item(OP_WRITE, 8'd0, 8'd255, '{16'h8000, 16'h0001, 16'h7FFF}, 0, 0);
      sample_at(0, 0);
      sample_at(32'h7FFFFFFF, 32'h7FFFFFFF);
      sample_at(32'h80000000, 32'h80000000);
      sample_at(32'h00000080, 32'h0000FF80);
      sample_at(32'h0000FFFF, 32'h00010000);
      sample_at(32'hFFFFFFFF, 32'h00008000);
      drain();

      foreach (widths[p]) begin
         write_csr(CSR_IMAGE_WIDTH, 16'(widths[p]));
         write_csr(CSR_IMAGE_HEIGHT, 16'(heights[p]));
         write_csr(CSR_EXPOSURE_GAIN, 16'(gains[p]));
         write_csr(CSR_BORDER_MODE, 16'(borders[p]));
         write_csr(CSR_FILTER_MODE, 16'(filters[p]));
         if (p == 2) begin
            send_idle_pct = 81;
            recv_idle_pct = 8;
         end else if (p == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         sample_at(0, 0);
         sample_at(32'h00010000, 32'h00010000);
         sample_at(32'hFFFF8000, 32'h7FFF0000);
         if (p == 5) begin
            // long receiver hold-off so the pipeline backs up into the request side
            hold_request = 400;
            random_items(60);
         end
         random_items(120);
         drain();
      end

      if (sb.errors == 0 && sb.expected_texels.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
